// ===== rtl/core/mf3_pkg.sv =====
// ----------------------------------------------------------------------------
// mf3_pkg: shared types, constants and helpers for the 3x3 RGB median filter
// Sizes of the line buffers and counters, the issue record passed from the
// control unit to the datapath, and the small compare networks of a lane.
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int WINDOW_TAPS = 9;
  localparam int NUM_CH      = 3;
  localparam int CH_W        = 8;
  localparam int PIX_W       = NUM_CH * CH_W;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int WEFF_W      = COL_W + 1;
  localparam int CFG_W_W     = 12;
  localparam int CFG_H_W     = 16;
  localparam int ROW_W       = CFG_H_W + 1;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int PIPE_DEPTH  = 3;

  localparam logic [CFG_W_W-1:0] WIDTH_RST  = CFG_W_W'(640);
  localparam logic [CFG_H_W-1:0] HEIGHT_RST = CFG_H_W'(480);

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_sel_e;

  typedef logic [CH_W-1:0]  ch_t;
  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [COL_W-1:0] col_t;
  typedef logic [ROW_W-1:0] row_t;

  // Item handed from the control unit to the line buffers and window
  typedef struct packed {
    logic enter;
    logic produce;
    logic inner;
    logic eof;
    col_t x;
  } issue_t;

  // Per-word tag carried beside the lane pipelines
  typedef struct packed {
    logic valid;
    logic inner;
    logic eof;
  } tag_t;

  typedef struct packed {
    ch_t lo;
    ch_t md;
    ch_t hi;
  } trio_t;

  function automatic trio_t sort3(input ch_t a, input ch_t b, input ch_t c);
    ch_t l1, h1, l2, h2, l3, h3;
    trio_t r;
    l1 = (a < b) ? a : b;
    h1 = (a < b) ? b : a;
    l2 = (h1 < c) ? h1 : c;
    h2 = (h1 < c) ? c : h1;
    l3 = (l1 < l2) ? l1 : l2;
    h3 = (l1 < l2) ? l2 : l1;
    r.lo = l3;
    r.md = h3;
    r.hi = h2;
    return r;
  endfunction

  function automatic ch_t max3(input ch_t a, input ch_t b, input ch_t c);
    ch_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic ch_t min3(input ch_t a, input ch_t b, input ch_t c);
    ch_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic ch_t med3(input ch_t a, input ch_t b, input ch_t c);
    trio_t t;
    t = sort3(a, b, c);
    return t.md;
  endfunction

endpackage

// ===== rtl/core/mf3_ctrl.sv =====
// ----------------------------------------------------------------------------
// mf3_ctrl: configuration registers and frame position counters
// Holds width and height, tracks the input and output raster positions and
// decides for each accepted word whether it enters the pipeline and whether
// it yields an output pixel (median or border passthrough).
// ----------------------------------------------------------------------------
module mf3_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic [mf3_pkg::ADDR_W-1:0]     paddr_i,
  input  logic [mf3_pkg::DATA_W-1:0]     pwdata_i,
  output logic [mf3_pkg::DATA_W-1:0]     prdata_o,
  output logic                           pready_o,
  input  logic                           accept_i,
  input  logic                           action_i,
  output mf3_pkg::issue_t                issue_o
);
  import mf3_pkg::*;

  logic [CFG_W_W-1:0] width_q;
  logic [CFG_H_W-1:0] height_q;
  col_t               in_col_q, in_col_d, out_col_q, out_col_d;
  row_t               in_row_q, in_row_d, out_row_q, out_row_d;

  logic [WEFF_W-1:0]  w_eff;
  row_t               h_eff;
  logic               restart, cfg_wr, due, last_in, last_out;
  col_t               x, ocol_e;
  row_t               row_e, orow_e;
  reg_sel_e           sel;

  assign pready_o = 1'b1;
  assign sel      = reg_sel_e'(paddr_i[ADDR_W-1]);
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_comb begin
    unique case (sel)
      REG_WIDTH:  prdata_o = DATA_W'(width_q);
      REG_HEIGHT: prdata_o = DATA_W'(height_q);
      default:    prdata_o = '0;
    endcase
  end

  always_comb begin
    if (width_q == '0) begin
      w_eff = WEFF_W'(1);
    end else if (int'(width_q) > MAX_WIDTH) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(width_q);
    end
    h_eff = (height_q == '0) ? ROW_W'(1) : ROW_W'(height_q);

    // a pixel after a complete frame opens the next one
    restart = !action_i && (in_row_q >= h_eff);
    x       = (WEFF_W'(in_col_q) >= w_eff || restart) ? '0 : in_col_q;
    row_e   = restart ? '0 : in_row_q;
    orow_e  = restart ? '0 : out_row_q;
    ocol_e  = restart ? '0 : out_col_q;

    issue_o.enter   = accept_i && (!action_i || (in_row_q >= h_eff && out_row_q < h_eff));
    due             = (row_e >= ROW_W'(2)) || (row_e == ROW_W'(1) && x != '0);
    issue_o.produce = due && (orow_e < h_eff);
    issue_o.inner   = (orow_e != '0) && ((orow_e + ROW_W'(1)) < h_eff) &&
                      (ocol_e != '0) && ((WEFF_W'(ocol_e) + WEFF_W'(1)) < w_eff);
    issue_o.eof     = (orow_e == h_eff - ROW_W'(1)) &&
                      (WEFF_W'(ocol_e) == w_eff - WEFF_W'(1));
    issue_o.x       = x;

    last_in  = (WEFF_W'(x) + WEFF_W'(1)) >= w_eff;
    last_out = (WEFF_W'(ocol_e) + WEFF_W'(1)) >= w_eff;

    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    priority if (cfg_wr) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (issue_o.enter) begin
      in_col_d  = last_in ? '0 : x + COL_W'(1);
      in_row_d  = last_in ? row_e + ROW_W'(1) : row_e;
      out_col_d = ocol_e;
      out_row_d = orow_e;
      if (issue_o.produce) begin
        out_col_d = last_out ? '0 : ocol_e + COL_W'(1);
        out_row_d = last_out ? orow_e + ROW_W'(1) : orow_e;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WIDTH_RST;
      height_q  <= HEIGHT_RST;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (sel)
          REG_WIDTH:  width_q  <= pwdata_i[CFG_W_W-1:0];
          REG_HEIGHT: height_q <= pwdata_i[CFG_H_W-1:0];
          default:    width_q  <= width_q;
        endcase
      end
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

endmodule

// ===== rtl/core/mf3_linebuf.sv =====
// ----------------------------------------------------------------------------
// mf3_linebuf: two line buffers holding the rows above the current one
// One registered read per word; the write of the previous word goes back at
// its column, with a bypass when both hit the same column in one cycle.
// ----------------------------------------------------------------------------
module mf3_linebuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  mf3_pkg::col_t rd_addr_i,
  input  logic          wr_en_i,
  input  mf3_pkg::col_t wr_addr_i,
  input  mf3_pkg::pix_t wr_pix_i,
  output mf3_pkg::pix_t top_o,
  output mf3_pkg::pix_t mid_o
);
  import mf3_pkg::*;

  pix_t older_mem [MAX_WIDTH];
  pix_t newer_mem [MAX_WIDTH];
  pix_t top_raw_q, mid_raw_q, byp_top_q, byp_mid_q;
  logic byp_q;

  assign top_o = byp_q ? byp_top_q : top_raw_q;
  assign mid_o = byp_q ? byp_mid_q : mid_raw_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      top_raw_q <= older_mem[rd_addr_i];
      mid_raw_q <= newer_mem[rd_addr_i];
    end
  end

  // the row above moves down into the older buffer
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      older_mem[wr_addr_i] <= mid_o;
      newer_mem[wr_addr_i] <= wr_pix_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      byp_top_q <= mid_o;
      byp_mid_q <= wr_pix_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

endmodule

// ===== rtl/core/mf3_lane.sv =====
// ----------------------------------------------------------------------------
// mf3_lane: median of nine 8-bit taps for one color channel
// Three registered steps: sort each row, reduce the columns, median of three.
// ----------------------------------------------------------------------------
module mf3_lane (
  input  logic        clk_i,
  input  logic        en_i,
  input  mf3_pkg::ch_t taps_i [mf3_pkg::WINDOW_TAPS],
  output mf3_pkg::ch_t med_o
);
  import mf3_pkg::*;

  trio_t rows_q [3];
  ch_t   max_lo_q, med_md_q, min_hi_q, med_q;

  assign med_o = med_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        rows_q[r] <= sort3(taps_i[3*r], taps_i[3*r+1], taps_i[3*r+2]);
      end
      max_lo_q <= max3(rows_q[0].lo, rows_q[1].lo, rows_q[2].lo);
      med_md_q <= med3(rows_q[0].md, rows_q[1].md, rows_q[2].md);
      min_hi_q <= min3(rows_q[0].hi, rows_q[1].hi, rows_q[2].hi);
      med_q    <= med3(max_lo_q, med_md_q, min_hi_q);
    end
  end

endmodule

// ===== rtl/core/median_filter_3x3_rgb_unit.sv =====
// ----------------------------------------------------------------------------
// median_filter_3x3_rgb_unit: streaming 3x3 per-channel median filter
// Line buffers, a 3x3 window, three median lanes and an output merge stage.
// ----------------------------------------------------------------------------
// Takes one word per clock and gives one word per clock when the output side
// is ready; the whole pipeline stalls together only while the output register
// holds a word that has not been taken. The edge that accepts the word that
// completes a pixel's window reads the line buffers; after it the window
// loads, the median lanes run and the output register is loaded. In raster
// terms the output trails the input by one row plus one pixel; after the
// last pixel send width+1 flush words (tuser high) to drain the frame.
// Border pixels pass through unchanged. The line buffers start with undefined
// contents and need no clearing after reset. Writing either register restarts
// the frame; write them only while idle.
module median_filter_3x3_rgb_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [23:0]                s_axis_tdata_i,  // in_ch0, in_ch1, in_ch2
  input  logic                       s_axis_tuser_i,  // action: 1 = flush
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [23:0]                m_axis_tdata_o,  // out_ch0, out_ch1, out_ch2
  output logic                       m_axis_tlast_o,  // end_of_frame
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic [mf3_pkg::ADDR_W-1:0] paddr_i,
  input  logic [mf3_pkg::DATA_W-1:0] pwdata_i,
  output logic [mf3_pkg::DATA_W-1:0] prdata_o,
  output logic                       pready_o
);
  import mf3_pkg::*;

  logic   en, accept;
  issue_t issue;

  logic   b_valid_q;
  tag_t   b_tag_q;
  col_t   b_x_q;
  pix_t   b_pix_q;
  pix_t   top, mid;

  pix_t   win_q [WINDOW_TAPS];
  tag_t   c_tag_q;
  tag_t   tag_q [PIPE_DEPTH];
  pix_t   ctr_q [PIPE_DEPTH];
  ch_t    med [NUM_CH];

  logic   out_valid_q;
  pix_t   out_pix_q;
  logic   out_last_q;

  assign en              = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && en;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_pix_q;
  assign m_axis_tlast_o  = out_last_q;

  mf3_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o),
    .accept_i  (accept),
    .action_i  (s_axis_tuser_i),
    .issue_o   (issue)
  );

  mf3_linebuf u_linebuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (issue.enter),
    .rd_addr_i (issue.x),
    .wr_en_i   (en && b_valid_q),
    .wr_addr_i (b_x_q),
    .wr_pix_i  (b_pix_q),
    .top_o     (top),
    .mid_o     (mid)
  );

  // read stage: word waits here for its line buffer data
  always_ff @(posedge clk_i) begin
    if (issue.enter) begin
      b_x_q         <= issue.x;
      b_pix_q       <= s_axis_tuser_i ? '0 : s_axis_tdata_i;
      b_tag_q.valid <= issue.produce;
      b_tag_q.inner <= issue.inner;
      b_tag_q.eof   <= issue.eof;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en) begin
      b_valid_q <= issue.enter;
    end
  end

  // window stage: shift each row left, load the new column on the right
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_TAPS; i++) begin
        win_q[i] <= '0;
      end
    end else if (en && b_valid_q) begin
      for (int r = 0; r < 3; r++) begin
        win_q[3*r]   <= win_q[3*r+1];
        win_q[3*r+1] <= win_q[3*r+2];
      end
      win_q[2] <= top;
      win_q[5] <= mid;
      win_q[8] <= b_pix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_tag_q <= '0;
      for (int s = 0; s < PIPE_DEPTH; s++) begin
        tag_q[s] <= '0;
      end
    end else if (en) begin
      c_tag_q.valid <= b_valid_q && b_tag_q.valid;
      c_tag_q.inner <= b_tag_q.inner;
      c_tag_q.eof   <= b_tag_q.eof;
      tag_q[0]      <= c_tag_q;
      for (int s = 1; s < PIPE_DEPTH; s++) begin
        tag_q[s] <= tag_q[s-1];
      end
    end
  end

  // carry the center pixel beside the lanes for border passthrough
  always_ff @(posedge clk_i) begin
    if (en) begin
      ctr_q[0] <= win_q[4];
      for (int s = 1; s < PIPE_DEPTH; s++) begin
        ctr_q[s] <= ctr_q[s-1];
      end
    end
  end

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
    ch_t taps [WINDOW_TAPS];
    for (genvar t = 0; t < WINDOW_TAPS; t++) begin : g_tap
      assign taps[t] = win_q[t][CH_W*ch +: CH_W];
    end
    mf3_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .taps_i (taps),
      .med_o  (med[ch])
    );
  end

  // merge: pick lane medians or the center pixel into the output word
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_pix_q  <= tag_q[PIPE_DEPTH-1].inner ? {med[2], med[1], med[0]}
                                              : ctr_q[PIPE_DEPTH-1];
      out_last_q <= tag_q[PIPE_DEPTH-1].eof;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= tag_q[PIPE_DEPTH-1].valid;
    end
  end

endmodule

// ===== rtl/core/mf3_checker.sv =====
// ----------------------------------------------------------------------------
// mf3_checker: port-level checks for the median filter unit
// Watches the stream and register ports of the top level over time.
// ----------------------------------------------------------------------------
module mf3_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tready_o,
  input logic                       m_axis_tvalid_o,
  input logic                       m_axis_tready_i,
  input logic [23:0]                m_axis_tdata_o,
  input logic                       m_axis_tlast_o,
  input logic                       psel_i,
  input logic                       penable_i,
  input logic                       pwrite_i,
  input logic                       pready_o,
  input logic [mf3_pkg::ADDR_W-1:0] paddr_i,
  input logic [mf3_pkg::DATA_W-1:0] pwdata_i,
  input logic [mf3_pkg::DATA_W-1:0] prdata_o
);
  import mf3_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled output word changed");

  // input side backs off only while an output word is stuck
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input not ready without output stall");

  a_width_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel_i && penable_i && pwrite_i && pready_o && !paddr_i[ADDR_W-1])
      ##1 !paddr_i[ADDR_W-1] |-> prdata_o[CFG_W_W-1:0] == $past(pwdata_i[CFG_W_W-1:0]))
    else $error("width register readback mismatch");

endmodule

bind median_filter_3x3_rgb_unit mf3_checker u_mf3_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .psel_i          (psel_i),
  .penable_i       (penable_i),
  .pwrite_i        (pwrite_i),
  .pready_o        (pready_o),
  .paddr_i         (paddr_i),
  .pwdata_i        (pwdata_i),
  .prdata_o        (prdata_o)
);

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the streaming 3x3 RGB median filter
// Drives pixel and flush words into the slave stream and programs the frame
// size over APB. A behavioral copy of the filter predicts every output pixel,
// and each word leaving the master stream is checked against the oldest
// prediction. Both stream sides idle at random, and the receiver stalls once
// for a long stretch so that the pipeline fills up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import mf3_pkg::*;

  localparam int RANDOM_ITEMS  = 1100;
  localparam int DRAIN_CYCLES  = 16;
  localparam int STALL_CYCLES  = 300;
  localparam int WATCHDOG_MAX  = 5000;
  localparam int IDLE_PERCENT  = 13;

  typedef struct packed {
    ch_t  c0;
    ch_t  c1;
    ch_t  c2;
    logic eof;
  } pixel_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                s_tvalid = 1'b0;
  logic [PIX_W-1:0]    s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tready = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;

  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [PIX_W-1:0]    m_axis_tdata_o;
  logic                m_axis_tlast_o;
  logic [DATA_W-1:0]   prdata_o;
  logic                pready_o;

  median_filter_3x3_rgb_unit u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),   // in_ch0, in_ch1, in_ch2
    .s_axis_tuser_i  (s_tuser),   // action
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),  // out_ch0, out_ch1, out_ch2
    .m_axis_tlast_o  (m_axis_tlast_o),  // end_of_frame
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata_o),
    .pready_o        (pready_o)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Filter predictor
  // --------------------------------------------------------------------------
  logic [CFG_W_W-1:0] cfg_width  = WIDTH_RST;
  logic [CFG_H_W-1:0] cfg_height = HEIGHT_RST;
  pix_t               line_old [MAX_WIDTH];
  pix_t               line_new [MAX_WIDTH];
  pix_t               win      [WINDOW_TAPS];
  int unsigned        in_col, in_row, out_col, out_row;

  pixel_out_t expected_pixels[$];

  int error_count    = 0;
  int words_sent     = 0;
  int useful_words   = 0;
  int pixels_checked = 0;
  int frames_started = 0;
  bit gaps_on        = 1'b1;
  int stall_req      = 0;

  function automatic int unsigned eff_width();
    int unsigned w;
    w = cfg_width;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    return (cfg_height < 1) ? 1 : cfg_height;
  endfunction

  function automatic void restart_counters();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic ch_t window_median(input int sh);
    ch_t v[WINDOW_TAPS];
    ch_t t;
    int  i, j;
    for (i = 0; i < WINDOW_TAPS; i++) v[i] = win[i][sh +: CH_W];
    for (i = 1; i < WINDOW_TAPS; i++) begin
      t = v[i];
      j = i - 1;
      while (j >= 0 && v[j] > t) begin
        v[j + 1] = v[j];
        j--;
      end
      v[j + 1] = t;
    end
    return v[WINDOW_TAPS / 2];
  endfunction

  // Shift one pixel into the line buffers and window; 1 when a pixel is due
  function automatic bit filter_advance(input pix_t pix, output pixel_out_t res);
    int unsigned w, h, x, r;
    pix_t        top, mid;
    bit          due, inner;
    res = '0;
    w = eff_width();
    h = eff_height();
    x = in_col;
    if (x >= w) x = 0;
    top = line_old[x];
    mid = line_new[x];
    for (r = 0; r < 3; r++) begin
      win[r * 3]     = win[r * 3 + 1];
      win[r * 3 + 1] = win[r * 3 + 2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = pix;
    line_old[x] = mid;
    line_new[x] = pix;

    due = (in_row >= 2) || (in_row == 1 && x >= 1);
    if (x + 1 >= w) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col = x + 1;
    end
    if (!due || out_row >= h) return 1'b0;

    inner = out_row >= 1 && out_row + 1 < h && out_col >= 1 && out_col + 1 < w;
    if (inner) begin
      res.c0 = window_median(0);
      res.c1 = window_median(8);
      res.c2 = window_median(16);
    end else begin
      res.c0 = win[4][7:0];
      res.c1 = win[4][15:8];
      res.c2 = win[4][23:16];
    end
    res.eof = (out_row == h - 1) && (out_col == w - 1);
    if (out_col + 1 >= w) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
    return 1'b1;
  endfunction

  function automatic bit filter_step(input logic flush, input pix_t pix,
                                     output pixel_out_t res, output bit ignored);
    int unsigned h;
    h = eff_height();
    ignored = 1'b0;
    res = '0;
    if (!flush) begin
      if (in_row >= h) begin
        restart_counters();
        frames_started++;
      end
      return filter_advance(pix, res);
    end
    if (in_row < h || out_row >= h) begin
      ignored = 1'b1;
      return 1'b0;
    end
    return filter_advance('0, res);
  endfunction

  // --------------------------------------------------------------------------
  // Reset, receiver, checker, watchdog
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  int stall_seen = 0;
  int stall_hold = 0;

  always @(posedge clk) begin
    if (stall_hold > 0) begin
      m_tready   <= 1'b0;
      stall_hold <= stall_hold - 1;
    end else if (stall_req != stall_seen) begin
      stall_seen <= stall_req;
      stall_hold <= STALL_CYCLES;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= gaps_on ? ($urandom_range(99) >= IDLE_PERCENT) : 1'b1;
    end
  end

  task automatic compare_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    pixel_out_t exp_pix;
    if (rst_n && m_axis_tvalid_o && m_tready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected word: expected none, got %h last %b", $time,
                 m_axis_tdata_o, m_axis_tlast_o);
        error_count++;
      end else begin
        exp_pix = expected_pixels.pop_front();
        compare_field("out_ch0", exp_pix.c0, m_axis_tdata_o[7:0]);
        compare_field("out_ch1", exp_pix.c1, m_axis_tdata_o[15:8]);
        compare_field("out_ch2", exp_pix.c2, m_axis_tdata_o[23:16]);
        compare_field("end_of_frame", {7'b0, exp_pix.eof}, {7'b0, m_axis_tlast_o});
        pixels_checked++;
      end
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_MAX) begin
      $display("%0t: watchdog: no handshake for %0d cycles", $time, WATCHDOG_MAX);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Bus tasks
  // --------------------------------------------------------------------------
  task automatic send_word(input logic flush, input pix_t pix);
    pixel_out_t res;
    bit         produced, ignored;
    while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tuser  <= flush;
    do @(posedge clk); while (!s_axis_tready_o);
    produced = filter_step(flush, pix, res, ignored);
    if (produced) expected_pixels.push_back(res);
    words_sent++;
    if (!ignored) useful_words++;
  endtask

  task automatic send_pixel(input pix_t pix);
    send_word(1'b0, pix);
  endtask

  task automatic send_flushes(input int count);
    repeat (count) send_word(1'b1, pix_t'($urandom));
  endtask

  // Drop valid, let every predicted pixel arrive, then let the pipeline settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input reg_sel_e sel,
                            input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {sel, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready_o);
    rdata   = prdata_o;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_check(input reg_sel_e sel);
    logic [DATA_W-1:0] rdata, exp_v;
    apb_access(1'b0, sel, '0, rdata);
    exp_v = (sel == REG_WIDTH) ? DATA_W'(cfg_width) : DATA_W'(cfg_height);
    if (rdata !== exp_v) begin
      $display("%0t: register %s readback: expected %h, got %h", $time, sel.name(),
               exp_v, rdata);
      error_count++;
    end
  endtask

  // Write with random junk above the register's width, then read it back
  task automatic write_reg(input reg_sel_e sel, input int unsigned value);
    logic [DATA_W-1:0] wdata, unused;
    wdata = DATA_W'($urandom);
    if (sel == REG_WIDTH) wdata[CFG_W_W-1:0] = value[CFG_W_W-1:0];
    else wdata[CFG_H_W-1:0] = value[CFG_H_W-1:0];
    apb_access(1'b1, sel, wdata, unused);
    if (sel == REG_WIDTH) cfg_width = wdata[CFG_W_W-1:0];
    else cfg_height = wdata[CFG_H_W-1:0];
    restart_counters();
    read_check(sel);
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h);
    wait_idle();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  function automatic pix_t rand_pixel(input bit coarse);
    pix_t p;
    p = pix_t'($urandom);
    // Few distinct levels force ties in the median network
    if (coarse) p = {8'($urandom_range(3) * 85), 8'($urandom_range(3) * 85),
                     8'($urandom_range(3) * 85)};
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_register_access();
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    read_check(REG_WIDTH);
    read_check(REG_HEIGHT);
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 3);
  endtask

  task automatic test_extreme_pixels();
    pix_t pixels[9];
    int   i;
    pixels = '{24'h000000, 24'hFFFFFF, 24'h000000,
               24'hFFFFFF, 24'h80FF01, 24'hFF00FF,
               24'h00FF00, 24'hFFFFFF, 24'h010203};
    set_frame(3, 3);
    for (i = 0; i < 9; i++) begin
      send_pixel(pixels[i]);
      if (i == 3) send_flushes(1);  // early flush, ignored
    end
    send_flushes(4);
    send_flushes(2);                // nothing pending
  endtask

  task automatic test_tiny_frames();
    // width and height zero fall back to one pixel
    set_frame(0, 0);
    send_pixel(24'hA5A5A5);
    send_flushes(2);
    send_pixel(24'h5A5A5A);
    // a new pixel after a complete frame drops the undrained one
    send_pixel(24'hC33C0F);
    send_flushes(3);
  endtask

  task automatic test_restart_on_write();
    int i;
    set_frame(4, 3);
    for (i = 0; i < 6; i++) send_pixel(rand_pixel(1'b0));
    wait_idle();
    write_reg(REG_HEIGHT, 3);
    for (i = 0; i < 12; i++) send_pixel(rand_pixel(1'b0));
    send_flushes(5);
  endtask

  task automatic test_tall_frame();
    int i;
    set_frame(3, 16'hFFFF);
    for (i = 0; i < 15; i++) send_pixel(rand_pixel(i[0]));
    send_flushes(1);
  endtask

  task automatic test_widest_row();
    int i;
    // width beyond the buffer depth: a partial first row gives no output yet
    set_frame(12'hFFF, 2);
    for (i = 0; i < 40; i++) send_pixel(rand_pixel(1'b0));
    send_flushes(2);
  endtask

  task automatic test_backpressure();
    int i;
    set_frame(6, 6);
    stall_req++;
    for (i = 0; i < 36; i++) send_pixel(rand_pixel(1'b0));
    send_flushes(7);
  endtask

  task automatic test_random_frames();
    int          frame, kind, npix, i, target;
    int unsigned w, h;
    bit          coarse;
    frame  = 0;
    target = useful_words + RANDOM_ITEMS;
    while (useful_words < target) begin
      frame++;
      gaps_on = !(frame >= 20 && frame < 32);
      if (frame == 1 || $urandom_range(3) != 0) begin
        w = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        h = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        set_frame(w, h);
      end
      w      = eff_width();
      h      = eff_height();
      npix   = w * h;
      coarse = ($urandom_range(3) == 0);
      kind   = $urandom_range(9);
      if (kind == 0) begin
        // broken frame: cut short, stray flushes
        npix = $urandom_range(1, npix);
        for (i = 0; i < npix; i++) send_pixel(rand_pixel(coarse));
        send_flushes($urandom_range(2));
      end else begin
        for (i = 0; i < npix; i++) begin
          send_pixel(rand_pixel(coarse));
          if (kind == 1 && $urandom_range(7) == 0) send_flushes(1);
        end
        if (kind == 2) send_flushes($urandom_range(w));
        else send_flushes(w + 1 + $urandom_range(2));
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    test_register_access();
    test_extreme_pixels();
    test_tiny_frames();
    test_restart_on_write();
    test_tall_frame();
    test_widest_row();
    test_backpressure();
    test_random_frames();
    wait_idle();
    $display("Summary: %0d words sent (%0d not ignored), %0d pixels checked", words_sent,
             useful_words, pixels_checked);
    $display("Summary: frames from 1x1 to 40x20, a 65535-row frame, an oversized width, %0d restarts",
             frames_started);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
